FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ATF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ATF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

FILE: rtl/atf_pkg.sv
// Shared types, constants and the arctangent table of the tilt angle filter.
package atf_pkg;

    localparam int WINDOW       = 16;
    localparam int CORDIC_STEPS = 14;

    localparam int SAMPLE_W    = 16;
    localparam int SLOT_W      = $clog2(WINDOW);
    localparam int SUM_W       = SAMPLE_W + SLOT_W;
    localparam int PRESCALE_SH = 16;
    localparam int CW          = SUM_W + PRESCALE_SH + 2;
    localparam int STEP_W      = $clog2(CORDIC_STEPS);
    localparam int TAB_IDX_W   = 5;
    localparam int Z_W         = 18;
    localparam int ANGLE_W     = 16;
    localparam int SPEED_W     = 16;
    localparam int CFG_W       = 15;
    localparam int PROD_W      = 2 * CFG_W;
    localparam int DIV_STEPS   = CFG_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam int PI_Q13 = 25736;

    localparam int REG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [REG_IDX_W-1:0] REG_MAX_ANGLE = 8'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_SPEED = 8'd1;
    localparam logic [CFG_W-1:0]     MAX_ANGLE_RST = 15'd6434;
    localparam logic [CFG_W-1:0]     MAX_SPEED_RST = 15'd5120;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
    } t_sums;

    typedef struct packed {
        logic [CFG_W-1:0] max_angle;
        logic [CFG_W-1:0] max_speed;
    } t_cfg;

    // round(atan(2^-i) * 8192)
    function automatic logic [Z_W-1:0] atan_q13(input logic [TAB_IDX_W-1:0] idx);
        logic [Z_W-1:0] v;
        unique case (idx)
            5'd0:    v = 18'd6434;
            5'd1:    v = 18'd3798;
            5'd2:    v = 18'd2007;
            5'd3:    v = 18'd1019;
            5'd4:    v = 18'd511;
            5'd5:    v = 18'd256;
            5'd6:    v = 18'd128;
            5'd7:    v = 18'd64;
            5'd8:    v = 18'd32;
            5'd9:    v = 18'd16;
            5'd10:   v = 18'd8;
            5'd11:   v = 18'd4;
            5'd12:   v = 18'd2;
            5'd13:   v = 18'd1;
            default: v = 18'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/atf_front.sv
// Sample intake: window rings, running sums, push of new sums to the queue.
module atf_front
    import atf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,  // [15:0] accel_x, [31:16] accel_y
    output logic                 o_push,
    output t_sums                o_sums,
    input  logic                 i_full
);

    logic signed [SAMPLE_W-1:0] r_ring_x [WINDOW];
    logic signed [SAMPLE_W-1:0] r_ring_y [WINDOW];
    logic signed [SUM_W-1:0]    r_sum_x, r_sum_y;
    logic [SLOT_W-1:0]          r_slot;

    logic signed [SAMPLE_W-1:0] ax, ay, old_x, old_y;
    logic signed [SUM_W-1:0]    n_sum_x, n_sum_y;
    logic [SLOT_W-1:0]          n_slot;

    assign ax    = s_axis_tdata[SAMPLE_W-1:0];
    assign ay    = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign old_x = r_ring_x[r_slot];
    assign old_y = r_ring_y[r_slot];

    // Drop the sample leaving the window, add the new one.
    assign n_sum_x = r_sum_x
                   + {{(SUM_W-SAMPLE_W){ax[SAMPLE_W-1]}}, ax}
                   - {{(SUM_W-SAMPLE_W){old_x[SAMPLE_W-1]}}, old_x};
    assign n_sum_y = r_sum_y
                   + {{(SUM_W-SAMPLE_W){ay[SAMPLE_W-1]}}, ay}
                   - {{(SUM_W-SAMPLE_W){old_y[SAMPLE_W-1]}}, old_y};
    assign n_slot  = (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;

    assign s_axis_tready = !i_full;
    assign o_push        = s_axis_tvalid && !i_full;
    assign o_sums.sum_x  = n_sum_x;
    assign o_sums.sum_y  = n_sum_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_ring_x[k] <= '0;
                r_ring_y[k] <= '0;
            end
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_slot  <= '0;
        end else if (o_push) begin
            r_ring_x[r_slot] <= ax;
            r_ring_y[r_slot] <= ay;
            r_sum_x          <= n_sum_x;
            r_sum_y          <= n_sum_y;
            r_slot           <= n_slot;
        end
    end

endmodule

FILE: rtl/atf_queue.sv
// Short queue of window sums between intake and angle engine.
module atf_queue
    import atf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_sums i_sums,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_sums o_sums
);

    t_sums               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr, r_rd;
    logic [Q_CNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_sums  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_sums;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/atf_back.sv
// Angle engine: CORDIC atan2, clamp, speed multiply and divide, output register.
module atf_back
    import atf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_sums       i_sums,
    output logic        o_pop,
    input  t_cfg        i_cfg,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // [15:0] tilt_angle, [31:16] side_speed
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CORD  = 3'd1;
    localparam logic [2:0] ST_CLAMP = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam logic signed [Z_W-1:0] PI_Z = Z_W'(PI_Q13);

    logic [2:0]                r_state;
    logic signed [CW-1:0]      r_x, r_y;
    logic signed [Z_W-1:0]     r_z;
    logic [STEP_W-1:0]         r_step;
    logic                      r_zero;
    logic signed [ANGLE_W-1:0] r_angle;
    logic                      r_neg;
    logic [CFG_W-1:0]          r_mag;
    logic [CFG_W-1:0]          r_rem, r_num, r_quo;
    logic [DIV_CNT_W-1:0]      r_div_cnt;
    logic                      r_ovalid;
    logic [31:0]               r_odata;

    logic signed [CW-1:0]      load_x, load_y, dx, dy;
    logic signed [Z_W-1:0]     atan_v, z_sat, z_clamp, lim;
    logic [PROD_W-1:0]         prod;
    logic [CFG_W:0]            trial;
    logic                      fits;
    logic signed [SPEED_W-1:0] speed;
    logic                      out_free;

    assign load_x = {{(CW-SUM_W-PRESCALE_SH){i_sums.sum_x[SUM_W-1]}},
                     i_sums.sum_x, {PRESCALE_SH{1'b0}}};
    assign load_y = {{(CW-SUM_W-PRESCALE_SH){i_sums.sum_y[SUM_W-1]}},
                     i_sums.sum_y, {PRESCALE_SH{1'b0}}};

    assign dx     = r_y >>> r_step;
    assign dy     = r_x >>> r_step;
    assign atan_v = $signed(atan_q13(TAB_IDX_W'(r_step)));

    // Saturate to +/- pi, force zero for a null vector, then clamp to the limit.
    assign lim = $signed({{(Z_W-CFG_W){1'b0}}, i_cfg.max_angle});
    always_comb begin
        if (r_zero) begin
            z_sat = '0;
        end else if (r_z > PI_Z) begin
            z_sat = PI_Z;
        end else if (r_z < -PI_Z) begin
            z_sat = -PI_Z;
        end else begin
            z_sat = r_z;
        end
        if (z_sat > lim) begin
            z_clamp = lim;
        end else if (z_sat < -lim) begin
            z_clamp = -lim;
        end else begin
            z_clamp = z_sat;
        end
    end

    assign prod  = PROD_W'(r_mag) * PROD_W'(i_cfg.max_speed);
    assign trial = {r_rem, r_num[CFG_W-1]};
    assign fits  = (trial >= {1'b0, i_cfg.max_angle});

    assign speed = (i_cfg.max_angle == '0) ? '0 :
                   r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

    assign out_free      = !r_ovalid || m_axis_tready;
    assign o_pop         = (r_state == ST_IDLE) && i_q_valid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    r_zero <= (i_sums.sum_x == '0) && (i_sums.sum_y == '0);
                    r_step <= '0;
                    if (i_sums.sum_x[SUM_W-1]) begin
                        r_x <= -load_x;
                        r_y <= -load_y;
                        r_z <= i_sums.sum_y[SUM_W-1] ? -PI_Z : PI_Z;
                    end else begin
                        r_x <= load_x;
                        r_y <= load_y;
                        r_z <= '0;
                    end
                end
            end
            ST_CORD: begin
                if (!r_y[CW-1]) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + atan_v;
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - atan_v;
                end
                r_step <= r_step + 1'b1;
            end
            ST_CLAMP: begin
                r_angle <= ANGLE_W'(z_clamp);
                r_neg   <= z_clamp[Z_W-1];
                r_mag   <= z_clamp[Z_W-1] ? CFG_W'(-z_clamp) : CFG_W'(z_clamp);
            end
            ST_MUL: begin
                // Upper half is already below the divisor: only low bits remain.
                r_rem     <= prod[PROD_W-1:CFG_W];
                r_num     <= prod[CFG_W-1:0];
                r_quo     <= '0;
                r_div_cnt <= '0;
            end
            ST_DIV: begin
                r_rem     <= fits ? CFG_W'(trial - {1'b0, i_cfg.max_angle})
                                  : CFG_W'(trial);
                r_num     <= {r_num[CFG_W-2:0], 1'b0};
                r_quo     <= {r_quo[CFG_W-2:0], fits};
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            ST_OUT: begin
                if (out_free) begin
                    r_odata <= {speed, r_angle};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if ((r_state == ST_OUT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE:  if (i_q_valid) r_state <= ST_CORD;
                ST_CORD:  if (r_step == STEP_W'(CORDIC_STEPS - 1)) r_state <= ST_CLAMP;
                ST_CLAMP: r_state <= ST_MUL;
                ST_MUL:   r_state <= ST_DIV;
                ST_DIV:   if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) r_state <= ST_OUT;
                ST_OUT:   if (out_free) r_state <= ST_IDLE;
                default:  r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/accel_tilt_angle_filter_top.sv
// Top level of the accelerometer tilt angle filter.
//
//  channel   direction  handshake                  word
//  s_axis    in         s_axis_tvalid/tready       accel_x [15:0], accel_y [31:16]
//  m_axis    out        m_axis_tvalid/tready       tilt_angle [15:0], side_speed [31:16]
//  cfg       in         i_cfg_valid/o_cfg_ready    index 0 max_angle, 1 max_speed
//
// In the angle engine each word passes load, 14 CORDIC steps, clamp, multiply,
// 15 divide steps and output; the engine takes the next word only once idle.
// Reset is synchronous: rings, sums, queue and engine clear at once, registers
// return to their defaults. A two-word queue absorbs input while the engine works;
// s_axis_tready drops when it is full, so a held m_axis word stalls the intake too.
module accel_tilt_angle_filter_top
    import atf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // [15:0] accel_x, [31:16] accel_y
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,   // [15:0] tilt_angle, [31:16] side_speed
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [REG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_sums push_sums, q_sums;
    logic  push, full, pop, q_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_angle <= MAX_ANGLE_RST;
            r_cfg.max_speed <= MAX_SPEED_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_MAX_ANGLE) begin
                r_cfg.max_angle <= i_cfg_data[CFG_W-1:0];
            end else if (i_cfg_index == REG_MAX_SPEED) begin
                r_cfg.max_speed <= i_cfg_data[CFG_W-1:0];
            end
        end
    end

    atf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .o_push        (push),
        .o_sums        (push_sums),
        .i_full        (full)
    );

    atf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_sums  (push_sums),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_sums  (q_sums)
    );

    atf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_sums        (q_sums),
        .o_pop         (pop),
        .i_cfg         (r_cfg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

FILE: rtl/atf_checker.sv
// Port-level checks of the tilt angle filter, bound to the top level.
`include "assert_macros.svh"

module atf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    logic signed [15:0] out_angle;
    logic [15:0]        out_speed;

    assign out_angle = m_axis_tdata[15:0];
    assign out_speed = m_axis_tdata[31:16];

    `ATF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ATF_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `ATF_ASSERT_NOW(a_angle_range, m_axis_tvalid, (out_angle <= 16'sd25736) && (out_angle >= -16'sd25736))
    `ATF_ASSERT_NOW(a_zero_angle_speed, m_axis_tvalid && (out_angle == 16'sd0), out_speed == 16'd0)

endmodule

bind accel_tilt_angle_filter_top atf_checker u_atf_checker (.*);

FILE: verif/tb_accel_tilt_angle_filter_top.sv
// Self-checking testbench of the tilt angle filter: directed, clamp-setting and random streams.
module tb_accel_tilt_angle_filter_top;
    import atf_pkg::*;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int DRAIN_CYCLES = 80;

    localparam logic [REG_IDX_W-1:0] REG_SPARE = 8'd2;
    localparam logic [REG_IDX_W-1:0] REG_TOP   = 8'hFF;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic signed [SPEED_W-1:0] speed;
    } t_tilt;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [REG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    accel_tilt_angle_filter_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial forever #2 i_clk = ~i_clk;

    // Predictor state: sample windows, exact sums and the two limits.
    int               win_x [WINDOW];
    int               win_y [WINDOW];
    longint           acc_x = 0;
    longint           acc_y = 0;
    int               slot_ptr = 0;
    logic [CFG_W-1:0] lim_angle = MAX_ANGLE_RST;
    logic [CFG_W-1:0] full_speed = MAX_SPEED_RST;
    longint           atan_lut [0:13] = '{6434, 3798, 2007, 1019, 511, 256, 128,
                                          64, 32, 16, 8, 4, 2, 1};

    t_tilt tilt_q [$];
    int    n_err = 0;
    int    n_sent = 0;
    int    n_seen = 0;
    int    n_cfg = 0;
    int    cycles = 0;
    bit    tx_steady = 0;
    bit    rx_steady = 0;

    function automatic longint cordic_angle(input longint sy, input longint sx);
        longint cx, cy, z, dx, dy;
        if (sx == 0 && sy == 0)
            return 0;
        cx = sx * 65536;
        cy = sy * 65536;
        z  = 0;
        // fold the left half-plane onto the right one
        if (cx < 0) begin
            z  = (cy >= 0) ? PI_Q13 : -PI_Q13;
            cx = -cx;
            cy = -cy;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
                cx += dx;
                cy -= dy;
                z  += atan_lut[i];
            end else begin
                cx -= dx;
                cy += dy;
                z  -= atan_lut[i];
            end
        end
        if (z > PI_Q13)
            z = PI_Q13;
        if (z < -PI_Q13)
            z = -PI_Q13;
        return z;
    endfunction

    function automatic t_tilt predict_tilt(input logic signed [15:0] ax, ay);
        t_tilt  r;
        longint ang, lim, spd;
        acc_x += ax - win_x[slot_ptr];
        acc_y += ay - win_y[slot_ptr];
        win_x[slot_ptr] = ax;
        win_y[slot_ptr] = ay;
        slot_ptr = (slot_ptr == WINDOW - 1) ? 0 : slot_ptr + 1;
        ang = cordic_angle(acc_y, acc_x);
        lim = longint'(lim_angle);
        if (ang > lim)
            ang = lim;
        if (ang < -lim)
            ang = -lim;
        spd = (lim != 0) ? (ang * longint'(full_speed)) / lim : 0;
        r.angle = ang[15:0];
        r.speed = spd[15:0];
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic int tx_gap();
        int r;
        if (tx_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_sample(input logic signed [15:0] ax, ay);
        int gap;
        gap = tx_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ay, ax};
        do @(posedge i_clk); while (!s_axis_tready);
        tilt_q.push_back(predict_tilt(ax, ay));
        n_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tilt_q.size() != 0);
    endtask

    task automatic cfg_handshake();
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Keep valid high across the writes; the spare bit of each word must be dropped.
    task automatic program_cfg(input logic [CFG_W-1:0] angle, speed, input bit with_spare);
        i_cfg_valid <= 1'b1;
        if (with_spare) begin
            i_cfg_index <= $urandom_range(0, 1) ? REG_SPARE : REG_TOP;
            i_cfg_data  <= 16'($urandom);
            cfg_handshake();
        end
        i_cfg_index <= REG_MAX_ANGLE;
        i_cfg_data  <= {1'($urandom), angle};
        cfg_handshake();
        lim_angle = angle;
        i_cfg_index <= REG_MAX_SPEED;
        i_cfg_data  <= {1'($urandom), speed};
        cfg_handshake();
        full_speed = speed;
        i_cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    task automatic test_directed();
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sh7FFF, 16'sd0);
        send_sample(16'sd0, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh8000);
        repeat (4) send_sample(16'sh8000, 16'sd0);
        repeat (2) send_sample(16'sd0, 16'sd1);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(-16'sd1, 16'sd1);
        send_sample(16'sd1, -16'sd1);
    endtask

    task automatic test_clamp_settings();
        logic [CFG_W-1:0] angles [6] = '{15'd0, 15'd1, 15'd25736, 15'd32767, 15'd6434,
                                        15'd3000};
        logic [CFG_W-1:0] speeds [6] = '{15'd32767, 15'd32767, 15'd0, 15'd32767, 15'd5120,
                                        15'd1};
        for (int k = 0; k < 6; k++) begin
            drain_results();
            program_cfg(angles[k], speeds[k], k < 2);
            send_sample(16'($urandom), 16'($urandom));
            send_sample(-16'sd20000, 16'sd12000);
        end
    endtask

    task automatic test_random_stream();
        int               sent, burst, mode, bx, by, amp, vx, vy, r;
        logic [CFG_W-1:0] ang, spd;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            drain_results();
            r = $urandom_range(0, 9);
            ang = (r == 0) ? 15'd0 : (r == 1) ? 15'($urandom_range(25737, 32767)) :
                  (r == 2) ? 15'd25736 : (r == 3) ? 15'd1 : 15'($urandom_range(1, 25736));
            r = $urandom_range(0, 9);
            spd = (r == 0) ? 15'd0 : (r == 1) ? 15'd32767 : 15'($urandom_range(0, 32767));
            program_cfg(ang, spd, $urandom_range(0, 3) == 0);
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(3, 6)) begin
                mode  = $urandom_range(0, 9);
                burst = (mode == 8) ? WINDOW : $urandom_range(8, 40);
                bx    = int'($urandom_range(0, 65535)) - 32768;
                by    = int'($urandom_range(0, 65535)) - 32768;
                amp   = $urandom_range(0, 255);
                for (int k = 0; k < burst; k++) begin
                    case (mode)
                        6, 7: begin
                            vx = int'($urandom_range(0, 65535)) - 32768;
                            vy = int'($urandom_range(0, 65535)) - 32768;
                        end
                        // flush the window so the sums return to zero
                        8: begin
                            vx = 0;
                            vy = 0;
                        end
                        // hug the negative x axis to reach the +/-pi edge
                        9: begin
                            vx = -int'($urandom_range(1000, 32768));
                            vy = int'($urandom_range(0, 6)) - 3;
                        end
                        default: begin
                            vx = bx + int'($urandom_range(0, 2 * amp)) - amp;
                            vy = by + int'($urandom_range(0, 2 * amp)) - amp;
                        end
                    endcase
                    send_sample(sat16(vx), sat16(vy));
                end
                sent += burst;
            end
        end
        tx_steady = 0;
        rx_steady = 0;
    endtask

    // Receiver: mostly ready, short stalls, an occasional long one.
    initial begin
        int hold, r;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (rx_steady) begin
                m_axis_tready <= 1'b1;
            end else if (hold > 0) begin
                m_axis_tready <= 1'b0;
                hold--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    m_axis_tready <= 1'b1;
                end else if (r < 95) begin
                    m_axis_tready <= 1'b0;
                    hold = $urandom_range(0, 3);
                end else begin
                    m_axis_tready <= 1'b0;
                    hold = $urandom_range(10, 40);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_tilt want;
        logic signed [15:0] got_angle, got_speed;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_angle = m_axis_tdata[15:0];
            got_speed = m_axis_tdata[31:16];
            n_seen++;
            if (tilt_q.size() == 0) begin
                n_err++;
                $display("%0t: unexpected word: angle %0d speed %0d",
                         $time, got_angle, got_speed);
            end else begin
                want = tilt_q.pop_front();
                if (got_angle !== want.angle || got_speed !== want.speed) begin
                    n_err++;
                    $display("%0t: expected angle %0d speed %0d, got angle %0d speed %0d",
                             $time, want.angle, want.speed, got_angle, got_speed);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words outstanding", $time, tilt_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_clamp_settings();
        test_random_stream();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Ran %0d samples, checked %0d filtered words over %0d register settings,",
                 n_sent, n_seen, n_cfg);
        $display("with zero, unit, full-pi and oversized clamp limits under random flow control.");
        if (n_err == 0 && tilt_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
